/* rtl/core/olemd_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered list package
// Shared action, status, cell and controller codes and default sizes.
// ----------------------------------------------------------------------------
package olemd_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF = $clog2(CAPACITY_DEF + 1);
	localparam int ACTION_WIDTH    = 3;
	localparam int STATUS_WIDTH    = 2;

	typedef enum logic [ACTION_WIDTH-1:0] {
		ACT_APPEND    = 3'd0,
		ACT_DEL_FIRST = 3'd1,
		ACT_DEL_MID   = 3'd2,
		ACT_DEL_LAST  = 3'd3,
		ACT_DISPLAY   = 3'd4
	} action_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_NEXT,
		CELL_HEAD
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SHOW
	} ctrl_state_t;

endpackage

/* rtl/core/olemd_ifs.sv */
// ----------------------------------------------------------------------------
// Ordered list channel interfaces
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface olemd_req_if #(
	parameter int VALUE_WIDTH = olemd_pkg::VALUE_WIDTH_DEF
);
	logic                                  valid;
	logic                                  ready;
	logic [olemd_pkg::ACTION_WIDTH-1:0]    action;
	logic signed [VALUE_WIDTH-1:0]         new_value;

	modport source (output valid, output action, output new_value, input ready);
	modport sink   (input valid, input action, input new_value, output ready);
endinterface

interface olemd_rsp_if #(
	parameter int VALUE_WIDTH = olemd_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = olemd_pkg::COUNT_WIDTH_DEF
);
	logic                                  valid;
	logic                                  ready;
	logic signed [VALUE_WIDTH-1:0]         item_value;
	logic [olemd_pkg::STATUS_WIDTH-1:0]    status;
	logic [COUNT_WIDTH-1:0]                entries_now;
	logic                                  final_result;

	modport source (output valid, output item_value, output status, output entries_now,
		output final_result, input ready);
	modport sink   (input valid, input item_value, input status, input entries_now,
		input final_result, output ready);
endinterface

/* rtl/core/olemd_cell.sv */
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list element; loads a new value or takes its neighbor's or the head's.
// ----------------------------------------------------------------------------
module olemd_cell #(
	parameter int VALUE_WIDTH = olemd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                     clk,
	input  olemd_pkg::cell_op_t      op,
	input  logic [VALUE_WIDTH-1:0]   load_value,
	input  logic [VALUE_WIDTH-1:0]   next_value,
	input  logic [VALUE_WIDTH-1:0]   head_value,
	output logic [VALUE_WIDTH-1:0]   value
);

	logic [VALUE_WIDTH-1:0] value_q;

	always_ff @(posedge clk) begin
		case (op)
			olemd_pkg::CELL_LOAD: value_q <= load_value;
			olemd_pkg::CELL_NEXT: value_q <= next_value;
			olemd_pkg::CELL_HEAD: value_q <= head_value;
			default:              value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

/* rtl/core/ordered_list_with_end_and_middle_delete.sv */
// ----------------------------------------------------------------------------
// Ordered list with end and middle delete
// Fixed-capacity ordered list kept in a chain of cells that shift toward the head.
// ----------------------------------------------------------------------------
// Channel | Modport | Word
// req     | sink    | action, new_value
// rsp     | source  | item_value, status, entries_now, final_result
//
// Append, all deletes and a display of an empty list give one word on rsp.
// Display gives one word per element, one per cycle while rsp is taken; the
// chain rotates by one cell for each word, so it returns to order at the end.
// req is held off during a display and while the rsp register is full and stalled.
// Reset clears the element count and the controller; cell contents are not reset.
// ----------------------------------------------------------------------------
module ordered_list_with_end_and_middle_delete #(
	parameter int CAPACITY    = olemd_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = olemd_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	olemd_req_if.sink     req,
	olemd_rsp_if.source   rsp
);

	logic [VALUE_WIDTH-1:0]   cell_value [CAPACITY];
	logic [VALUE_WIDTH-1:0]   cell_next  [CAPACITY];
	olemd_pkg::cell_op_t      cell_op    [CAPACITY];

	olemd_pkg::ctrl_state_t   state_q;
	olemd_pkg::ctrl_state_t   state_d;
	logic [COUNT_WIDTH-1:0]   count_q;
	logic [COUNT_WIDTH-1:0]   count_d;
	logic [COUNT_WIDTH-1:0]   left_q;
	logic [COUNT_WIDTH-1:0]   left_d;
	logic [COUNT_WIDTH-1:0]   del_pos;
	logic [COUNT_WIDTH-1:0]   last_pos;

	logic                     out_free;
	logic                     accept;
	logic                     load_out;
	logic                     del_req;
	logic [VALUE_WIDTH-1:0]   out_item;
	olemd_pkg::status_t       out_status;
	logic                     out_final;

	logic                     rsp_valid_q;
	logic [VALUE_WIDTH-1:0]   item_q;
	olemd_pkg::status_t       status_q;
	logic [COUNT_WIDTH-1:0]   entries_q;
	logic                     final_q;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == olemd_pkg::ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign last_pos  = count_q - COUNT_WIDTH'(1);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_tail
			assign cell_next[i] = cell_value[i];
		end else begin : g_body
			assign cell_next[i] = cell_value[i+1];
		end

		olemd_cell #(
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (cell_op[i]),
			.load_value (req.new_value),
			.next_value (cell_next[i]),
			.head_value (cell_value[0]),
			.value      (cell_value[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			olemd_pkg::ST_IDLE: begin
				if (accept && req.action == olemd_pkg::ACT_DISPLAY && count_q != '0) begin
					state_d = olemd_pkg::ST_SHOW;
				end
			end
			olemd_pkg::ST_SHOW: begin
				if (out_free && left_q == COUNT_WIDTH'(1)) begin
					state_d = olemd_pkg::ST_IDLE;
				end
			end
			default: state_d = olemd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		count_d    = count_q;
		left_d     = left_q;
		load_out   = 1'b0;
		del_req    = 1'b0;
		del_pos    = '0;
		out_item   = '0;
		out_status = olemd_pkg::STAT_OK;
		out_final  = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			cell_op[i] = olemd_pkg::CELL_HOLD;
		end

		case (state_q)
			olemd_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.action)
						olemd_pkg::ACT_APPEND: begin
							load_out = 1'b1;
							if (count_q == COUNT_WIDTH'(CAPACITY)) begin
								out_status = olemd_pkg::STAT_FULL;
							end else begin
								for (int i = 0; i < CAPACITY; i++) begin
									if (COUNT_WIDTH'(i) == count_q) begin
										cell_op[i] = olemd_pkg::CELL_LOAD;
									end
								end
								count_d = count_q + COUNT_WIDTH'(1);
							end
						end
						olemd_pkg::ACT_DEL_FIRST: begin
							load_out = 1'b1;
							del_req  = 1'b1;
							del_pos  = '0;
						end
						olemd_pkg::ACT_DEL_MID: begin
							load_out = 1'b1;
							del_req  = 1'b1;
							del_pos  = last_pos >> 1;
						end
						olemd_pkg::ACT_DEL_LAST: begin
							load_out = 1'b1;
							del_req  = 1'b1;
							del_pos  = last_pos;
						end
						olemd_pkg::ACT_DISPLAY: begin
							if (count_q == '0) begin
								load_out   = 1'b1;
								out_status = olemd_pkg::STAT_EMPTY;
							end else begin
								left_d = count_q;
							end
						end
						default: begin
							load_out = 1'b1;
						end
					endcase

					if (del_req) begin
						if (count_q == '0) begin
							out_status = olemd_pkg::STAT_EMPTY;
						end else begin
							for (int i = 0; i < CAPACITY; i++) begin
								if (COUNT_WIDTH'(i) >= del_pos) begin
									cell_op[i] = olemd_pkg::CELL_NEXT;
								end
							end
							count_d = last_pos;
						end
					end
				end
			end
			olemd_pkg::ST_SHOW: begin
				if (out_free) begin
					load_out  = 1'b1;
					out_item  = cell_value[0];
					out_final = (left_q == COUNT_WIDTH'(1));
					left_d    = left_q - COUNT_WIDTH'(1);
					for (int i = 0; i < CAPACITY; i++) begin
						if (COUNT_WIDTH'(i) < last_pos) begin
							cell_op[i] = olemd_pkg::CELL_NEXT;
						end else if (COUNT_WIDTH'(i) == last_pos) begin
							cell_op[i] = olemd_pkg::CELL_HEAD;
						end
					end
				end
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olemd_pkg::ST_IDLE;
			count_q     <= '0;
			left_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			left_q  <= left_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			item_q    <= out_item;
			status_q  <= out_status;
			entries_q <= count_d;
			final_q   <= out_final;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.item_value   = item_q;
	assign rsp.status       = status_q;
	assign rsp.entries_now  = entries_q;
	assign rsp.final_result = final_q;

endmodule
